// ----- rtl/lswc_pkg.sv -----
// Shared types and constants of the line segment window clipper.
package lswc_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CODE = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  // Bit positions inside a 4-bit outcode.
  localparam int unsigned OC_LEFT   = 0;
  localparam int unsigned OC_RIGHT  = 1;
  localparam int unsigned OC_BOTTOM = 2;
  localparam int unsigned OC_TOP    = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // Clip steps allowed before a segment is given up as rejected.
  localparam logic [3:0] MAX_STEPS = 4'd8;

  // Window reset values.
  localparam int RST_LEFT   = 100;
  localparam int RST_RIGHT  = 300;
  localparam int RST_TOP    = 100;
  localparam int RST_BOTTOM = 250;

endpackage

// ----- rtl/line_segment_window_clipper_core.sv -----
// Cohen-Sutherland line clipper with one shared multiplier and a serial divider.
//
// Channel  | Direction | Handshake                    | Contents
// s_axis   | in        | s_axis_tvalid_i/tready_o     | one segment, two endpoints
// m_axis   | out       | m_axis_tvalid_o/tready_i     | visible flag and clipped endpoints
// cfg      | in        | cfg_we_i (no wait)           | window edge registers
//
// Each clip step runs an outcode decision (ST_CODE), one multiply (ST_MUL), a restoring
// divide of one quotient bit per cycle (ST_DIV) and an endpoint update (ST_UPD). After the
// result is loaded from ST_OUT, the sequencer returns to ST_IDLE before the next segment can
// be taken. The number of clip steps is at most 4 for a valid window and never exceeds 8.
// Reset restores the default window and empties the output register. s_axis_tready_o is
// high only while the sequencer is idle; a finished result waits in ST_OUT while the output
// register is still full, and the output register holds its result until it is taken.
module line_segment_window_clipper_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Configuration write port.
  input  logic                                        cfg_we_i,
  input  logic [1:0]                                  cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]                      cfg_data_i,
  // Input segment: start_x, start_y, end_x, end_y from bit 0 up, zero padded.
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata_i,
  // Result: clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero padded.
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]          m_axis_tdata_o,
  // Result flag: visible.
  output logic                                        m_axis_tuser_o
);
  import lswc_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int DATA_W = ((4*COORD_WIDTH+7)/8)*8;
  localparam int PAD_W  = DATA_W - 4*COORD_WIDTH;
  localparam int CNT_W  = $clog2(COORD_WIDTH+1);

  state_e state_q, state_d;

  logic signed [W-1:0] wl_q, wr_q, wt_q, wb_q;
  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [W-1:0] x0_d, y0_d, x1_d, y1_d;
  logic [3:0]          step_q, step_d;
  logic                vis_q, vis_d;

  // Operands of the current clip step.
  logic                side_q, side_d;    // endpoint being moved: 0 start, 1 end
  logic                fix_x_q, fix_x_d;  // clipping against a vertical edge
  logic [W-1:0]        fix_q, fix_d;
  logic [W-1:0]        base_q, base_d;
  logic                neg_q, neg_d;
  logic                dz_q, dz_d;
  logic [W:0]          md_q, md_d, mn_q, mn_d, mden_q, mden_d;

  // Divider state: remainder and product bits shifted out as quotient bits shift in.
  logic [W:0]          rem_q, rem_d, lo_q, lo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_vis_q;
  logic [W-1:0]        ox0_q, oy0_q, ox1_q, oy1_q;
  logic                out_load;

  // Outcode and step setup.
  logic [3:0]          c0, c1, csel;
  logic                win_bad;
  logic [W:0]          dx, dy, nl, nr, nb, nt;
  logic [W:0]          delta, num, den;
  logic [2*W+1:0]      prod;
  logic [W+1:0]        trial;
  logic                qbit;
  logic [W:0]          quo;
  logic [W+1:0]        sum;
  logic [W-1:0]        newv, nx, ny;

  always_comb begin
    c0 = '0;
    c1 = '0;
    if (x0_q < wl_q) c0[OC_LEFT] = 1'b1;
    else if (x0_q > wr_q) c0[OC_RIGHT] = 1'b1;
    if (y0_q > wb_q) c0[OC_BOTTOM] = 1'b1;
    else if (y0_q < wt_q) c0[OC_TOP] = 1'b1;
    if (x1_q < wl_q) c1[OC_LEFT] = 1'b1;
    else if (x1_q > wr_q) c1[OC_RIGHT] = 1'b1;
    if (y1_q > wb_q) c1[OC_BOTTOM] = 1'b1;
    else if (y1_q < wt_q) c1[OC_TOP] = 1'b1;
  end

  assign win_bad = (wl_q > wr_q) || (wt_q > wb_q);
  assign csel    = (c0 != '0) ? c0 : c1;

  // Differences carry one extra bit so that they never wrap.
  assign dx = {x1_q[W-1], x1_q} - {x0_q[W-1], x0_q};
  assign dy = {y1_q[W-1], y1_q} - {y0_q[W-1], y0_q};
  assign nl = {wl_q[W-1], wl_q} - {x0_q[W-1], x0_q};
  assign nr = {wr_q[W-1], wr_q} - {x0_q[W-1], x0_q};
  assign nb = {wb_q[W-1], wb_q} - {y0_q[W-1], y0_q};
  assign nt = {wt_q[W-1], wt_q} - {y0_q[W-1], y0_q};

  always_comb begin
    if (csel[OC_LEFT]) begin
      fix_x_d = 1'b1; fix_d = wl_q; base_d = y0_q; delta = dy; num = nl; den = dx;
    end else if (csel[OC_RIGHT]) begin
      fix_x_d = 1'b1; fix_d = wr_q; base_d = y0_q; delta = dy; num = nr; den = dx;
    end else if (csel[OC_BOTTOM]) begin
      fix_x_d = 1'b0; fix_d = wb_q; base_d = x0_q; delta = dx; num = nb; den = dy;
    end else begin
      fix_x_d = 1'b0; fix_d = wt_q; base_d = x0_q; delta = dx; num = nt; den = dy;
    end
    side_d = (c0 == '0);
    neg_d  = delta[W] ^ num[W] ^ den[W];
    dz_d   = (den == '0);
    md_d   = delta[W] ? (~delta + 1'b1) : delta;
    mn_d   = num[W] ? (~num + 1'b1) : num;
    mden_d = den[W] ? (~den + 1'b1) : den;
  end

  // The quotient never exceeds |delta|, so the upper product half is already below
  // the divisor and only COORD_WIDTH+1 quotient bits remain to be found.
  assign prod  = md_q * mn_q;
  assign trial = {rem_q, lo_q[W]};
  assign qbit  = (trial >= {1'b0, mden_q});

  assign quo  = dz_q ? {(W+1){1'b0}} : lo_q;
  assign sum  = neg_q ? ({{2{base_q[W-1]}}, base_q} - {1'b0, quo})
                      : ({{2{base_q[W-1]}}, base_q} + {1'b0, quo});
  assign newv = sum[W-1:0];
  assign nx   = fix_x_q ? fix_q : newv;
  assign ny   = fix_x_q ? newv : fix_q;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    x1_d    = x1_q;
    y1_d    = y1_q;
    step_d  = step_q;
    vis_d   = vis_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          x0_d    = s_axis_tdata_i[W-1:0];
          y0_d    = s_axis_tdata_i[2*W-1:W];
          x1_d    = s_axis_tdata_i[3*W-1:2*W];
          y1_d    = s_axis_tdata_i[4*W-1:3*W];
          step_d  = '0;
          state_d = ST_CODE;
        end
      end
      ST_CODE: begin
        if (win_bad || step_q == MAX_STEPS || (c0 & c1) != '0) begin
          vis_d   = 1'b0;
          state_d = ST_OUT;
        end else if ((c0 | c1) == '0) begin
          vis_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_d   = prod[2*W+1:W+1];
        lo_d    = prod[W:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = qbit ? (W+1)'(trial - {1'b0, mden_q}) : trial[W:0];
        lo_d  = {lo_q[W-1:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (side_q) begin
          x1_d = nx;
          y1_d = ny;
        end else begin
          x0_d = nx;
          y0_d = ny;
        end
        step_d  = step_q + 1'b1;
        state_d = ST_CODE;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
      wl_q        <= W'(RST_LEFT);
      wr_q        <= W'(RST_RIGHT);
      wt_q        <= W'(RST_TOP);
      wb_q        <= W'(RST_BOTTOM);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LEFT:   wl_q <= cfg_data_i;
          REG_RIGHT:  wr_q <= cfg_data_i;
          REG_TOP:    wt_q <= cfg_data_i;
          REG_BOTTOM: wb_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    vis_q <= vis_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (state_q == ST_CODE) begin
      side_q  <= side_d;
      fix_x_q <= fix_x_d;
      fix_q   <= fix_d;
      base_q  <= base_d;
      neg_q   <= neg_d;
      dz_q    <= dz_d;
      md_q    <= md_d;
      mn_q    <= mn_d;
      mden_q  <= mden_d;
    end
    if (out_load) begin
      // A rejected segment reports all coordinates as zero.
      out_vis_q <= vis_q;
      ox0_q     <= vis_q ? x0_q : '0;
      oy0_q     <= vis_q ? y0_q : '0;
      ox1_q     <= vis_q ? x1_q : '0;
      oy1_q     <= vis_q ? y1_q : '0;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_vis_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, oy1_q, ox1_q, oy0_q, ox0_q};

endmodule
